### sv/ubxfe_pkg.sv
// shared types and constants for the ubx frame encoder
// used by the front, queue, back, top level and checker; no dependencies

package ubxfe_pkg;

    // sync bytes that open every frame
    localparam logic [7:0] SYNC_ONE = 8'hB5;
    localparam logic [7:0] SYNC_TWO = 8'h62;

    // input item kinds
    localparam logic KIND_HDR = 1'b0;
    localparam logic KIND_PAY = 1'b1;

    // command queue between front and back
    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);

    // byte positions within one command
    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] HSTEP_SYNC1 = 3'd0;
    localparam logic [STEP_W-1:0] HSTEP_SYNC2 = 3'd1;
    localparam logic [STEP_W-1:0] HSTEP_CLASS = 3'd2;
    localparam logic [STEP_W-1:0] HSTEP_ID    = 3'd3;
    localparam logic [STEP_W-1:0] HSTEP_LENLO = 3'd4;
    localparam logic [STEP_W-1:0] HSTEP_LENHI = 3'd5;
    localparam logic [STEP_W-1:0] HSTEP_SUMA  = 3'd6;
    localparam logic [STEP_W-1:0] HSTEP_SUMB  = 3'd7;
    localparam logic [STEP_W-1:0] PSTEP_BYTE  = 3'd0;
    localparam logic [STEP_W-1:0] PSTEP_SUMA  = 3'd1;
    localparam logic [STEP_W-1:0] PSTEP_SUMB  = 3'd2;

    typedef enum logic {
        OP_HDR = 1'b0,
        OP_PAY = 1'b1
    } op_t;

    // one classified job for the back end
    typedef struct packed {
        op_t        op;
        logic [7:0] b0;     // class, or the payload byte
        logic [7:0] b1;     // id
        logic [7:0] b2;     // length low
        logic [7:0] b3;     // length high
        logic       ck;     // checksum pair follows
        logic [7:0] sum_a;
        logic [7:0] sum_b;
    } cmd_t;

    // queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

### sv/ubxfe_front.sv
// front end: accepts items, runs the fletcher sums and frame tracking,
// and pushes one command per item that produces bytes; uses ubxfe_pkg

module ubxfe_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                kind,
    input  logic [7:0]          msg_class,
    input  logic [7:0]          msg_id,
    input  logic [15:0]         payload_len,
    input  logic [7:0]          payload_byte,
    input  ubxfe_pkg::q_stat_t  q_stat,
    output logic                push,
    output ubxfe_pkg::cmd_t     cmd
);

    logic [7:0]  sum_a_reg, sum_a_next;
    logic [7:0]  sum_b_reg, sum_b_next;
    logic [15:0] bytes_left_reg, bytes_left_next;
    logic        frame_open_reg, frame_open_next;
    logic        accept;
    logic [7:0]  ha1, ha2, ha3, ha4;
    logic [7:0]  hb2, hb3, hb4;
    logic [7:0]  pa, pb;
    logic [15:0] left_dec;

    // hold off input while the queue has no room
    assign in_stall = q_stat.full;
    assign accept   = in_valid & ~in_stall;

    // header sums over class, id and both length bytes
    always_comb
    begin
        ha1 = msg_class;
        ha2 = ha1 + msg_id;
        hb2 = ha1 + ha2;
        ha3 = ha2 + payload_len[7:0];
        hb3 = hb2 + ha3;
        ha4 = ha3 + payload_len[15:8];
        hb4 = hb3 + ha4;
    end

    // payload sums and length countdown
    always_comb
    begin
        pa       = sum_a_reg + payload_byte;
        pb       = sum_b_reg + pa;
        left_dec = bytes_left_reg - 16'd1;
    end

    // next state and the command for this transaction
    always_comb
    begin
        sum_a_next      = sum_a_reg;
        sum_b_next      = sum_b_reg;
        bytes_left_next = bytes_left_reg;
        frame_open_next = frame_open_reg;
        push            = 1'b0;
        cmd.op          = ubxfe_pkg::OP_HDR;
        cmd.b0          = msg_class;
        cmd.b1          = msg_id;
        cmd.b2          = payload_len[7:0];
        cmd.b3          = payload_len[15:8];
        cmd.ck          = 1'b0;
        cmd.sum_a       = ha4;
        cmd.sum_b       = hb4;
        if (kind == ubxfe_pkg::KIND_HDR)
        begin
            cmd.ck     = (payload_len == 16'd0);
            sum_a_next = ha4;
            sum_b_next = hb4;
            if (accept)
            begin
                push            = 1'b1;
                bytes_left_next = payload_len;
                frame_open_next = (payload_len != 16'd0);
            end
        end
        else
        begin
            cmd.op    = ubxfe_pkg::OP_PAY;
            cmd.b0    = payload_byte;
            cmd.ck    = (left_dec == 16'd0);
            cmd.sum_a = pa;
            cmd.sum_b = pb;
            if (accept && frame_open_reg)
            begin
                push            = 1'b1;
                sum_a_next      = pa;
                sum_b_next      = pb;
                bytes_left_next = left_dec;
                frame_open_next = (left_dec != 16'd0);
            end
        end
    end

    // checksum and frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_a_reg      <= 8'd0;
            sum_b_reg      <= 8'd0;
            bytes_left_reg <= 16'd0;
            frame_open_reg <= 1'b0;
        end
        else if (accept)
        begin
            sum_a_reg      <= sum_a_next;
            sum_b_reg      <= sum_b_next;
            bytes_left_reg <= bytes_left_next;
            frame_open_reg <= frame_open_next;
        end
    end

endmodule

### sv/ubxfe_cmdq.sv
// short command queue between front and back end
// register based, depth from ubxfe_pkg

module ubxfe_cmdq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  ubxfe_pkg::cmd_t     push_cmd,
    input  logic                pop,
    output ubxfe_pkg::cmd_t     head,
    output ubxfe_pkg::q_stat_t  q_stat
);

    localparam logic [ubxfe_pkg::CMDQ_AW-1:0] LAST_PTR =
        ubxfe_pkg::CMDQ_AW'(ubxfe_pkg::CMDQ_DEPTH - 1);
    localparam logic [ubxfe_pkg::CMDQ_AW:0] FULL_CNT =
        (ubxfe_pkg::CMDQ_AW + 1)'(ubxfe_pkg::CMDQ_DEPTH);

    ubxfe_pkg::cmd_t                 entry_reg [ubxfe_pkg::CMDQ_DEPTH];
    logic [ubxfe_pkg::CMDQ_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [ubxfe_pkg::CMDQ_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [ubxfe_pkg::CMDQ_AW:0]     count_reg, count_next;
    logic                            do_push, do_pop;

    assign q_stat.full  = (count_reg == FULL_CNT);
    assign q_stat.empty = (count_reg == '0);
    assign head         = entry_reg[rd_ptr_reg];
    assign do_push      = push & ~q_stat.full;
    assign do_pop       = pop & ~q_stat.empty;

    // pointer and count update with explicit wrap
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

### sv/ubxfe_back.sv
// back end: walks each queued command byte by byte into the output register
// uses ubxfe_pkg

module ubxfe_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  ubxfe_pkg::cmd_t                   head,
    input  ubxfe_pkg::q_stat_t                q_stat,
    output logic                              pop,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [7:0]                        out_byte,
    output logic                              frame_end,
    output logic                              run_last
);

    logic [ubxfe_pkg::STEP_W-1:0] step_reg, step_next;
    logic [ubxfe_pkg::STEP_W-1:0] last_step;
    logic                         out_valid_reg, out_valid_next;
    logic [7:0]                   out_byte_reg;
    logic                         frame_end_reg;
    logic                         run_last_reg;
    logic [7:0]                   cur_byte;
    logic                         is_last;
    logic                         out_load;
    logic                         send;

    // final byte position of the head command
    always_comb
    begin
        case (head.op)
            ubxfe_pkg::OP_HDR:
                last_step = head.ck ? ubxfe_pkg::HSTEP_SUMB : ubxfe_pkg::HSTEP_LENHI;
            ubxfe_pkg::OP_PAY:
                last_step = head.ck ? ubxfe_pkg::PSTEP_SUMB : ubxfe_pkg::PSTEP_BYTE;
            default:
                last_step = ubxfe_pkg::PSTEP_BYTE;
        endcase
    end

    // byte select for the current position
    always_comb
    begin
        cur_byte = head.sum_b;
        if (head.op == ubxfe_pkg::OP_HDR)
        begin
            case (step_reg)
                ubxfe_pkg::HSTEP_SYNC1: cur_byte = ubxfe_pkg::SYNC_ONE;
                ubxfe_pkg::HSTEP_SYNC2: cur_byte = ubxfe_pkg::SYNC_TWO;
                ubxfe_pkg::HSTEP_CLASS: cur_byte = head.b0;
                ubxfe_pkg::HSTEP_ID:    cur_byte = head.b1;
                ubxfe_pkg::HSTEP_LENLO: cur_byte = head.b2;
                ubxfe_pkg::HSTEP_LENHI: cur_byte = head.b3;
                ubxfe_pkg::HSTEP_SUMA:  cur_byte = head.sum_a;
                default:                cur_byte = head.sum_b;
            endcase
        end
        else
        begin
            case (step_reg)
                ubxfe_pkg::PSTEP_BYTE: cur_byte = head.b0;
                ubxfe_pkg::PSTEP_SUMA: cur_byte = head.sum_a;
                default:               cur_byte = head.sum_b;
            endcase
        end
    end

    // advance when the output register is free or being emptied
    assign out_load = ~out_valid_reg | ~out_stall;
    assign send     = out_load & ~q_stat.empty;
    assign is_last  = (step_reg == last_step);
    assign pop      = send & is_last;

    always_comb
    begin
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = send;
        if (send)
            step_next = is_last ? '0 : step_reg + 1'b1;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload register
    always_ff @(posedge clk)
    begin
        if (send)
        begin
            out_byte_reg  <= cur_byte;
            frame_end_reg <= head.ck & is_last;
            run_last_reg  <= is_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign frame_end = frame_end_reg;
    assign run_last  = run_last_reg;

endmodule

### sv/ubx_frame_encoder.sv
// top level of the ubx frame encoder: front end, command queue, back end
// depends on ubxfe_pkg, ubxfe_front, ubxfe_cmdq, ubxfe_back
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------------------
//  in      | input     | in_valid / in_stall  | kind, msg_class, msg_id, payload_len,
//          |           |                      | payload_byte
//  out     | output    | out_valid / out_stall| out_byte, frame_end, run_last
//
// one input transaction per cycle while the 4-entry command queue has room;
// the output emits one byte per cycle while out_stall is low; a header yields 6 output
// bytes (8 with a zero length) and a payload byte 1 (3 when it closes the frame).
// with an empty queue an accepted item passes the queue entry, then the output register.
// rst_n clears the checksum and frame state, the queue pointers and out_valid.
// out_stall holds the output register; in_stall rises once the queue is full.

module ubx_frame_encoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic [7:0]  msg_class,
    input  logic [7:0]  msg_id,
    input  logic [15:0] payload_len,
    input  logic [7:0]  payload_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        frame_end,
    output logic        run_last
);

    ubxfe_pkg::q_stat_t q_stat;
    ubxfe_pkg::cmd_t    push_cmd;
    ubxfe_pkg::cmd_t    head;
    logic               push;
    logic               pop;

    // classify and checksum
    ubxfe_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .msg_class    (msg_class),
        .msg_id       (msg_id),
        .payload_len  (payload_len),
        .payload_byte (payload_byte),
        .q_stat       (q_stat),
        .push         (push),
        .cmd          (push_cmd)
    );

    // decoupling queue
    ubxfe_cmdq u_cmdq (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .q_stat   (q_stat)
    );

    // byte sequencer and output register
    ubxfe_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_stat    (q_stat),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .frame_end (frame_end),
        .run_last  (run_last)
    );

endmodule

### sv/ubxfe_chk.sv
// port level checker for the ubx frame encoder, bound to the top level
// depends on ubxfe_pkg

module ubxfe_chk (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        kind,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [7:0]  out_byte,
    input  logic        frame_end,
    input  logic        run_last
);

    logic seen_hdr_reg;

    // remember whether any header transaction has been taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seen_hdr_reg <= 1'b0;
        else if (in_valid && !in_stall && kind == ubxfe_pkg::KIND_HDR)
            seen_hdr_reg <= 1'b1;
    end

    // a stalled output transaction holds its byte
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte))
        else $error("output byte changed while stalled");

    // the checksum B byte always ends the work of its input item
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_end |-> run_last)
        else $error("frame end without run_last");

    // no output before a header has opened a frame
    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> seen_hdr_reg)
        else $error("output without any header");

endmodule

bind ubx_frame_encoder ubxfe_chk u_ubxfe_chk (.*);

### bench/testbench.sv
// self-checking testbench for the ubx frame encoder: directed and random frames
// depends on ubxfe_pkg and ubx_frame_encoder; holds its own frame and checksum predictor

module testbench;

    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 80;
    localparam int RANDOM_ITEMS = 250;
    localparam int DRAIN_CYCLES = 20;

    // one predicted output byte
    typedef struct {
        logic [7:0] data;
        logic       fend;
        logic       rlast;
    } frame_byte_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        kind;
    logic [7:0]  msg_class;
    logic [7:0]  msg_id;
    logic [15:0] payload_len;
    logic [7:0]  payload_byte;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  out_byte;
    logic        frame_end;
    logic        run_last;

    // predictor state
    logic [7:0]  ck_a;
    logic [7:0]  ck_b;
    logic [15:0] remain;
    logic        in_frame;

    frame_byte_t framed_bytes[$];
    int          mismatches = 0;
    int          productive_items = 0;
    int          cycles = 0;
    bit          idle_on = 1'b1;
    bit          hold_req = 1'b0;

    ubx_frame_encoder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .msg_class    (msg_class),
        .msg_id       (msg_id),
        .payload_len  (payload_len),
        .payload_byte (payload_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_byte     (out_byte),
        .frame_end    (frame_end),
        .run_last     (run_last)
    );

    // clock, period 10
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t timeout with %0d bytes still expected", $time, framed_bytes.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // predictor helpers
    task automatic push_byte(input logic [7:0] b, input logic fe);
        frame_byte_t fb;
        fb.data  = b;
        fb.fend  = fe;
        fb.rlast = 1'b0;
        framed_bytes.push_back(fb);
    endtask

    task automatic push_summed(input logic [7:0] b);
        ck_a = ck_a + b;
        ck_b = ck_b + ck_a;
        push_byte(b, 1'b0);
    endtask

    task automatic push_checksum();
        push_byte(ck_a, 1'b0);
        push_byte(ck_b, 1'b1);
        in_frame = 1'b0;
        remain   = '0;
    endtask

    // expected output bytes for one accepted transaction
    task automatic encode_item(input logic k, input logic [7:0] cls, input logic [7:0] id,
                               input logic [15:0] len, input logic [7:0] pb);
        int before_n;
        before_n = framed_bytes.size();
        if (k == ubxfe_pkg::KIND_HDR)
        begin
            ck_a = '0;
            ck_b = '0;
            push_byte(ubxfe_pkg::SYNC_ONE, 1'b0);
            push_byte(ubxfe_pkg::SYNC_TWO, 1'b0);
            push_summed(cls);
            push_summed(id);
            push_summed(len[7:0]);
            push_summed(len[15:8]);
            if (len == 16'd0)
                push_checksum();
            else
            begin
                remain   = len;
                in_frame = 1'b1;
            end
        end
        else if (in_frame)
        begin
            push_summed(pb);
            remain = remain - 16'd1;
            if (remain == 16'd0)
                push_checksum();
        end
        if (framed_bytes.size() > before_n)
        begin
            framed_bytes[framed_bytes.size() - 1].rlast = 1'b1;
            productive_items++;
        end
    endtask

    // drive one input transaction and wait for its handshake
    task automatic send_item(input logic k, input logic [7:0] cls, input logic [7:0] id,
                             input logic [15:0] len, input logic [7:0] pb);
        int gap;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     <= 1'b1;
        kind         <= k;
        msg_class    <= cls;
        msg_id       <= id;
        payload_len  <= len;
        payload_byte <= pb;
        do @(posedge clk); while (in_stall);
        encode_item(k, cls, id, len, pb);
    endtask

    // unused fields get random values
    task automatic send_header(input logic [7:0] cls, input logic [7:0] id,
                               input logic [15:0] len);
        send_item(ubxfe_pkg::KIND_HDR, cls, id, len, 8'($urandom));
    endtask

    task automatic send_payload(input logic [7:0] pb);
        send_item(ubxfe_pkg::KIND_PAY, 8'($urandom), 8'($urandom), 16'($urandom), pb);
    endtask

    // receiver: random stall before each result, long hold on request
    initial
    begin
        int n;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                n = LONG_HOLD;
            end
            else
                n = idle_on ? $urandom_range(0, 4) : 0;
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(negedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    // compare each output transaction with the oldest prediction
    always @(posedge clk)
    begin
        frame_byte_t fb;
        if (rst_n && out_valid && !out_stall)
        begin
            if (framed_bytes.size() == 0)
            begin
                $display("%0t unexpected byte: expected none, actual out_byte=%02h", $time,
                         out_byte);
                mismatches++;
            end
            else
            begin
                fb = framed_bytes.pop_front();
                if (out_byte !== fb.data)
                begin
                    $display("%0t out_byte mismatch: expected %02h, actual %02h", $time,
                             fb.data, out_byte);
                    mismatches++;
                end
                if (frame_end !== fb.fend)
                begin
                    $display("%0t frame_end mismatch: expected %0b, actual %0b", $time,
                             fb.fend, frame_end);
                    mismatches++;
                end
                if (run_last !== fb.rlast)
                begin
                    $display("%0t run_last mismatch: expected %0b, actual %0b", $time,
                             fb.rlast, run_last);
                    mismatches++;
                end
            end
        end
    end

    // zero length frames, with extreme class and id
    task automatic test_zero_length();
        send_header(8'h00, 8'h00, 16'h0000);
        send_header(8'hFF, 8'hFF, 16'h0000);
    endtask

    // payload with no frame open is dropped
    task automatic test_stray_payload();
        send_payload(8'hFF);
        send_payload(8'h00);
    endtask

    // complete short frames, checksum after the last payload byte
    task automatic test_short_frames();
        send_header(8'h06, 8'h24, 16'h0002);
        send_payload(8'h00);
        send_payload(8'hFF);
        send_payload(8'h3C);
        send_header(8'h01, 8'h07, 16'h0001);
        send_payload(8'hA5);
    endtask

    // a header during an open frame abandons it
    task automatic test_abandoned_frame();
        send_header(8'hAA, 8'h55, 16'hFFFF);
        send_payload(8'h5A);
        send_header(8'h55, 8'hAA, 16'h8001);
        send_header(8'h0F, 8'hF0, 16'h0003);
        send_payload(8'h12);
        send_payload(8'h34);
        send_payload(8'h56);
    endtask

    // receiver holds off while the sender keeps offering, so the input stalls
    task automatic test_backpressure();
        hold_req = 1'b1;
        send_header(8'($urandom), 8'($urandom), 16'd24);
        repeat (24) send_payload(8'($urandom));
    endtask

    // random frames, mostly well formed, some broken or stray
    task automatic test_random_frames();
        int pick;
        int len;
        int cut;
        while (productive_items < RANDOM_ITEMS)
        begin
            idle_on = ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 9);
            if (pick == 0)
                send_payload(8'($urandom));
            else if (pick == 1)
            begin
                // header with a wide length, cut short by the next header
                send_header(8'($urandom), 8'($urandom), 16'($urandom));
                cut = $urandom_range(0, 3);
                repeat (cut) send_payload(8'($urandom));
            end
            else
            begin
                len = $urandom_range(0, 10);
                send_header(8'($urandom), 8'($urandom), 16'(len));
                repeat (len) send_payload(8'($urandom));
            end
        end
        idle_on = 1'b1;
    endtask

    // main sequence
    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        kind         = ubxfe_pkg::KIND_HDR;
        msg_class    = '0;
        msg_id       = '0;
        payload_len  = '0;
        payload_byte = '0;
        ck_a         = '0;
        ck_b         = '0;
        remain       = '0;
        in_frame     = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_stray_payload();
        test_zero_length();
        test_short_frames();
        test_stray_payload();
        test_abandoned_frame();
        test_backpressure();
        test_random_frames();

        @(negedge clk);
        in_valid <= 1'b0;
        while (framed_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### filelist.f
sv/ubxfe_pkg.sv
sv/ubxfe_front.sv
sv/ubxfe_cmdq.sv
sv/ubxfe_back.sv
sv/ubx_frame_encoder.sv
sv/ubxfe_chk.sv
bench/testbench.sv
